// ----- hw/rtl/vpac_pkg.sv -----
// ============================================================================
// vpac_pkg
// Shared widths, word types and pipeline record for the vector pair |cos| block.
// ============================================================================
package vpac_pkg;

    // Input component width, two's complement Q16.16.
    localparam int COMPONENT_WIDTH = 32;
    localparam int LEN_W     = $clog2(COMPONENT_WIDTH + 1);
    localparam int FRAC_OUT  = 30;
    localparam int MAG_W     = FRAC_OUT;         // normalized magnitude, < 2^30
    localparam int PROD_W    = 2 * MAG_W;        // one squared magnitude
    localparam int SUM_W     = PROD_W + 2;       // sum of three squares
    localparam int ROOT_W    = SUM_W / 2;        // square root bits
    localparam int SQ_REM_W  = ROOT_W + 2;       // root remainder
    localparam int DIV_REM_W = ROOT_W + 1;       // partial remainder of division
    localparam int Q_W       = FRAC_OUT + 1;     // quotient, at most 2^30
    localparam int UNIT_W    = 32;
    localparam int COS_W     = 31;
    localparam int DOT_W     = 2 * UNIT_W;
    localparam int LANES     = 6;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] first_x;
        logic signed [COMPONENT_WIDTH-1:0] first_y;
        logic signed [COMPONENT_WIDTH-1:0] first_z;
        logic signed [COMPONENT_WIDTH-1:0] second_x;
        logic signed [COMPONENT_WIDTH-1:0] second_y;
        logic signed [COMPONENT_WIDTH-1:0] second_z;
    } in_word_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_first_x;
        logic signed [UNIT_W-1:0] unit_first_y;
        logic signed [UNIT_W-1:0] unit_first_z;
        logic signed [UNIT_W-1:0] unit_second_x;
        logic signed [UNIT_W-1:0] unit_second_y;
        logic signed [UNIT_W-1:0] unit_second_z;
        logic        [COS_W-1:0]  abs_cosine;
    } out_word_t;

    // Record carried down the cell chain. Lanes 0..2 are the first vector,
    // lanes 3..5 the second.
    typedef struct packed {
        logic [LANES-1:0]                neg;
        logic [1:0]                      zero;
        logic [LANES-1:0][MAG_W-1:0]     mag;
        logic [1:0][SUM_W-1:0]           sq_s;
        logic [1:0][SQ_REM_W-1:0]        sq_rem;
        logic [1:0][ROOT_W-1:0]          sq_root;
        logic [LANES-1:0][DIV_REM_W-1:0] dv_rem;
        logic [LANES-1:0][Q_W-1:0]       dv_q;
    } work_t;

endpackage

// ----- hw/rtl/vpac_front.sv -----
// ============================================================================
// vpac_front
// Sign and magnitude split, leading-one search and normalizing shift.
// ============================================================================
module vpac_front (
    input  logic [2:0][vpac_pkg::COMPONENT_WIDTH-1:0] comp,
    output logic [2:0]                                neg,
    output logic [2:0][vpac_pkg::MAG_W-1:0]           mag,
    output logic                                      zero
);
    localparam int W = vpac_pkg::COMPONENT_WIDTH;
    localparam int EXT_W = W + vpac_pkg::MAG_W;
    localparam logic [vpac_pkg::LEN_W-1:0] FRAC_L = vpac_pkg::LEN_W'(vpac_pkg::MAG_W);

    logic [2:0][W-1:0] raw_mag;
    logic [W-1:0]      max_mag;
    logic [vpac_pkg::LEN_W-1:0] len;

    // Magnitudes and their maximum.
    always_comb begin
        max_mag = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i]     = comp[i][W-1];
            raw_mag[i] = comp[i][W-1] ? (~comp[i] + 1'b1) : comp[i];
            if (raw_mag[i] > max_mag) begin
                max_mag = raw_mag[i];
            end
        end
        zero = (max_mag == '0);
    end

    // Bit length of the largest magnitude.
    always_comb begin
        len = '0;
        for (int b = 0; b < W; b++) begin
            if (max_mag[b]) begin
                len = vpac_pkg::LEN_W'(b + 1);
            end
        end
    end

    // Bring the largest magnitude into [2^29, 2^30).
    always_comb begin
        logic [EXT_W-1:0] ext;
        logic [EXT_W-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            ext = EXT_W'(raw_mag[i]);
            if (len > FRAC_L) begin
                sh = ext >> (len - FRAC_L);
            end else begin
                sh = ext << (FRAC_L - len);
            end
            mag[i] = sh[vpac_pkg::MAG_W-1:0];
        end
    end
endmodule

// ----- hw/rtl/vpac_sqrt_cell.sv -----
// ============================================================================
// vpac_sqrt_cell
// One digit step of the integer square root, both vectors side by side.
// ============================================================================
module vpac_sqrt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  vpac_pkg::work_t in_work,
    output logic            out_valid,
    output vpac_pkg::work_t out_work
);
    localparam int RW = vpac_pkg::SQ_REM_W + 2;

    logic            valid_reg;
    vpac_pkg::work_t work_reg;
    vpac_pkg::work_t work_next;

    // Take the next pair of radicand bits and try to subtract 4*root + 1.
    always_comb begin
        logic [RW-1:0] r;
        logic [RW-1:0] t;
        work_next = in_work;
        for (int v = 0; v < 2; v++) begin
            r = {in_work.sq_rem[v], in_work.sq_s[v][vpac_pkg::SUM_W-1 -: 2]};
            t = RW'({in_work.sq_root[v], 2'b01});
            if (r >= t) begin
                work_next.sq_rem[v]  = vpac_pkg::SQ_REM_W'(r - t);
                work_next.sq_root[v] = {in_work.sq_root[v][vpac_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                work_next.sq_rem[v]  = r[vpac_pkg::SQ_REM_W-1:0];
                work_next.sq_root[v] = {in_work.sq_root[v][vpac_pkg::ROOT_W-2:0], 1'b0};
            end
            work_next.sq_s[v] = {in_work.sq_s[v][vpac_pkg::SUM_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;
endmodule

// ----- hw/rtl/vpac_div_cell.sv -----
// ============================================================================
// vpac_div_cell
// One quotient bit of restoring division for all six components.
// ============================================================================
module vpac_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  vpac_pkg::work_t in_work,
    output logic            out_valid,
    output vpac_pkg::work_t out_work
);
    localparam int RW = vpac_pkg::DIV_REM_W;

    logic            valid_reg;
    vpac_pkg::work_t work_reg;
    vpac_pkg::work_t work_next;

    // Compare against the vector length, subtract, then shift in a zero.
    always_comb begin
        logic [RW-1:0] d;
        logic [RW-1:0] r;
        logic          qbit;
        work_next = in_work;
        for (int i = 0; i < vpac_pkg::LANES; i++) begin
            d    = RW'(in_work.sq_root[i / 3]);
            qbit = (in_work.dv_rem[i] >= d);
            r    = qbit ? (in_work.dv_rem[i] - d) : in_work.dv_rem[i];
            work_next.dv_rem[i] = {r[RW-2:0], 1'b0};
            work_next.dv_q[i]   = {in_work.dv_q[i][vpac_pkg::Q_W-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;
endmodule

// ----- hw/rtl/vector_pair_abs_cosine_top.sv -----
// ============================================================================
// vector_pair_abs_cosine_top
// Normalizes two 3D vectors and returns them with |cos| of their angle.
// ============================================================================
// Throughput: one word per cycle; 31 root cells and 31 divider cells each
// produce one bit per word, all in flight at once.
// The whole pipeline holds while a result word waits on m_ready.
// Reset: synchronous active-low aresetn clears all valid flags; data is not reset.
module vector_pair_abs_cosine_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vpac_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vpac_pkg::out_word_t m_data
);
    localparam int ROOT_W = vpac_pkg::ROOT_W;
    localparam int Q_W    = vpac_pkg::Q_W;
    localparam int UNIT_W = vpac_pkg::UNIT_W;
    localparam int DOT_W  = vpac_pkg::DOT_W;
    localparam logic [DOT_W-1:0] ONE_OUT = DOT_W'(1) << vpac_pkg::FRAC_OUT;

    logic adv;

    logic [2:0]                        neg_a, neg_b;
    logic [2:0][vpac_pkg::MAG_W-1:0]   mag_a, mag_b;
    logic                              zero_a, zero_b;

    logic            front_valid_reg, prod_valid_reg, sum_valid_reg;
    vpac_pkg::work_t front_reg, prod_reg, sum_reg;
    vpac_pkg::work_t front_next, sum_next;
    logic [vpac_pkg::LANES-1:0][vpac_pkg::PROD_W-1:0] sq_reg;

    logic            sq_vld [0:ROOT_W];
    vpac_pkg::work_t sq_wrk [0:ROOT_W];
    logic            dv_vld [0:Q_W];
    vpac_pkg::work_t dv_wrk [0:Q_W];

    logic                                   dot_valid_reg;
    logic [vpac_pkg::LANES-1:0][UNIT_W-1:0] unit_reg;
    logic signed [2:0][DOT_W-1:0]           dprod_reg;
    logic                                   m_valid_reg;
    vpac_pkg::out_word_t                    m_data_reg;

    // The pipeline moves when the output register is free or being emptied.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    vpac_front u_front_a (
        .comp ({s_data.first_z, s_data.first_y, s_data.first_x}),
        .neg  (neg_a),
        .mag  (mag_a),
        .zero (zero_a)
    );

    vpac_front u_front_b (
        .comp ({s_data.second_z, s_data.second_y, s_data.second_x}),
        .neg  (neg_b),
        .mag  (mag_b),
        .zero (zero_b)
    );

    // Record entering the chain: signs, zero flags and normalized magnitudes.
    always_comb begin
        front_next      = '0;
        front_next.neg  = {neg_b, neg_a};
        front_next.zero = {zero_b, zero_a};
        front_next.mag  = {mag_b, mag_a};
    end

    // Sum of squares per vector, with the root state cleared.
    always_comb begin
        sum_next = prod_reg;
        for (int v = 0; v < 2; v++) begin
            sum_next.sq_s[v] = vpac_pkg::SUM_W'(sq_reg[3*v])
                             + vpac_pkg::SUM_W'(sq_reg[3*v+1])
                             + vpac_pkg::SUM_W'(sq_reg[3*v+2]);
            sum_next.sq_rem[v]  = '0;
            sum_next.sq_root[v] = '0;
        end
    end

    // Front, squaring and summing stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
            prod_valid_reg  <= 1'b0;
            sum_valid_reg   <= 1'b0;
        end else if (adv) begin
            front_valid_reg <= s_valid;
            prod_valid_reg  <= front_valid_reg;
            sum_valid_reg   <= prod_valid_reg;
        end
        if (adv) begin
            front_reg <= front_next;
            prod_reg  <= front_reg;
            for (int i = 0; i < vpac_pkg::LANES; i++) begin
                sq_reg[i] <= front_reg.mag[i] * front_reg.mag[i];
            end
            sum_reg <= sum_next;
        end
    end

    // Square root chain, one root bit per cell.
    assign sq_vld[0] = sum_valid_reg;
    assign sq_wrk[0] = sum_reg;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        vpac_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (sq_vld[k]),
            .in_work   (sq_wrk[k]),
            .out_valid (sq_vld[k+1]),
            .out_work  (sq_wrk[k+1])
        );
    end

    // Load the dividends: each magnitude starts as the partial remainder.
    always_comb begin
        dv_wrk[0] = sq_wrk[ROOT_W];
        for (int i = 0; i < vpac_pkg::LANES; i++) begin
            dv_wrk[0].dv_rem[i] = vpac_pkg::DIV_REM_W'(sq_wrk[ROOT_W].mag[i]);
            dv_wrk[0].dv_q[i]   = '0;
        end
    end
    assign dv_vld[0] = sq_vld[ROOT_W];

    // Division chain, one quotient bit per cell.
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        vpac_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (dv_vld[k]),
            .in_work   (dv_wrk[k]),
            .out_valid (dv_vld[k+1]),
            .out_work  (dv_wrk[k+1])
        );
    end

    // Signed unit components and pairwise products.
    always_ff @(posedge aclk) begin
        logic [vpac_pkg::LANES-1:0][UNIT_W-1:0] u;
        for (int i = 0; i < vpac_pkg::LANES; i++) begin
            u[i] = UNIT_W'(dv_wrk[Q_W].dv_q[i]);
            if (dv_wrk[Q_W].zero[i / 3]) begin
                u[i] = '0;
            end else if (dv_wrk[Q_W].neg[i]) begin
                u[i] = ~u[i] + 1'b1;
            end
        end
        if (!aresetn) begin
            dot_valid_reg <= 1'b0;
        end else if (adv) begin
            dot_valid_reg <= dv_vld[Q_W];
        end
        if (adv) begin
            unit_reg <= u;
            for (int i = 0; i < 3; i++) begin
                dprod_reg[i] <= DOT_W'($signed(u[i]) * $signed(u[i+3]));
            end
        end
    end

    // Dot sum, absolute value, scale and saturate into the output register.
    always_ff @(posedge aclk) begin
        logic signed [DOT_W-1:0] dot;
        logic [DOT_W-1:0]        mag;
        logic [DOT_W-1:0]        cosv;
        dot  = dprod_reg[0] + dprod_reg[1] + dprod_reg[2];
        mag  = dot[DOT_W-1] ? (~dot + 1'b1) : dot;
        cosv = mag >> vpac_pkg::FRAC_OUT;
        if (cosv > ONE_OUT) begin
            cosv = ONE_OUT;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dot_valid_reg;
        end
        if (adv) begin
            m_data_reg.unit_first_x  <= unit_reg[0];
            m_data_reg.unit_first_y  <= unit_reg[1];
            m_data_reg.unit_first_z  <= unit_reg[2];
            m_data_reg.unit_second_x <= unit_reg[3];
            m_data_reg.unit_second_y <= unit_reg[4];
            m_data_reg.unit_second_z <= unit_reg[5];
            m_data_reg.abs_cosine    <= cosv[vpac_pkg::COS_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A returned cosine never exceeds one.
    a_cos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.abs_cosine <= vpac_pkg::COS_W'(ONE_OUT)))
        else $error("abs_cosine above one");

    // A zero first vector gives a zero cosine.
    a_zero_cos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.unit_first_x == '0 && m_data.unit_first_y == '0
         && m_data.unit_first_z == '0) |-> (m_data.abs_cosine == '0))
        else $error("nonzero cosine for zero vector");

    // The lane 0 quotient leaving the divider chain never exceeds one unless the first vector is zero.
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld[Q_W] |-> (dv_wrk[Q_W].dv_q[0] <= Q_W'(ONE_OUT)
                         || dv_wrk[Q_W].zero[0]))
        else $error("unit component above one");
endmodule

// ----- dv/vector_pair_abs_cosine_top_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// vector_pair_abs_cosine_top_tb
// Checks the vector pair |cos| block against a behavioral predictor. A short
// table of directed words runs first, then random vector pairs under several
// sender and receiver idling patterns. Every result word is compared field by
// field with the oldest expected word.
// ============================================================================
module vector_pair_abs_cosine_top_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LATENCY      = 67;
    localparam int RANDOM_WORDS = 900;
    localparam int CW           = vpac_pkg::COMPONENT_WIDTH;
    localparam int FRAC_OUT     = vpac_pkg::FRAC_OUT;
    localparam int UNIT_W       = vpac_pkg::UNIT_W;
    localparam int COS_W        = vpac_pkg::COS_W;

    // One row of the directed stimulus table.
    typedef struct {
        vpac_pkg::in_word_t  stim;
        bit                  typed;
        vpac_pkg::out_word_t want;
    } row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    vpac_pkg::in_word_t  s_data;
    logic                m_valid;
    logic                m_ready = 1'b0;
    vpac_pkg::out_word_t m_data;

    vpac_pkg::out_word_t expected_words[$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    row_t                directed_rows[$];

    vector_pair_abs_cosine_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Integer square root, floor.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scales one vector to unit length, Q1.30; a zero vector stays zero.
    function automatic void make_unit(input logic [CW-1:0] comp[3],
                                      output longint unit[3]);
        longint unsigned mag[3];
        bit              neg[3];
        longint unsigned top;
        longint unsigned sum;
        longint unsigned root;
        longint unsigned q;
        int              blen;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = comp[i][CW-1];
            mag[i] = neg[i] ? longint'(-$signed({1'b1, comp[i]}))
                            : longint'(comp[i]);
            if (mag[i] > top) top = mag[i];
        end
        if (top == 0) begin
            for (int i = 0; i < 3; i++) unit[i] = 0;
            return;
        end
        blen = 0;
        while (blen < 64 && (top >> blen) != 0) blen++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (blen > FRAC_OUT) mag[i] = mag[i] >> (blen - FRAC_OUT);
            else                 mag[i] = mag[i] << (FRAC_OUT - blen);
            sum += mag[i] * mag[i];
        end
        root = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] << FRAC_OUT) / root;
            if (q > (64'd1 << FRAC_OUT)) q = 64'd1 << FRAC_OUT;
            unit[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    // Predicts the result word for one vector pair.
    function automatic vpac_pkg::out_word_t predict_abs_cosine(input vpac_pkg::in_word_t w);
        logic [CW-1:0]       va[3];
        logic [CW-1:0]       vb[3];
        longint              ua[3];
        longint              ub[3];
        longint              dot;
        longint unsigned     mag;
        vpac_pkg::out_word_t r;
        va = '{w.first_x, w.first_y, w.first_z};
        vb = '{w.second_x, w.second_y, w.second_z};
        make_unit(va, ua);
        make_unit(vb, ub);
        dot = 0;
        for (int i = 0; i < 3; i++) dot += ua[i] * ub[i];
        mag = (dot < 0) ? longint'(-dot) : dot;
        mag = mag >> FRAC_OUT;
        if (mag > (64'd1 << FRAC_OUT)) mag = 64'd1 << FRAC_OUT;
        r.unit_first_x  = ua[0][UNIT_W-1:0];
        r.unit_first_y  = ua[1][UNIT_W-1:0];
        r.unit_first_z  = ua[2][UNIT_W-1:0];
        r.unit_second_x = ub[0][UNIT_W-1:0];
        r.unit_second_y = ub[1][UNIT_W-1:0];
        r.unit_second_z = ub[2][UNIT_W-1:0];
        r.abs_cosine    = mag[COS_W-1:0];
        return r;
    endfunction

    // Random component: full range half the time, else small, extreme or shifted down.
    function automatic logic [CW-1:0] random_component();
        case ($urandom_range(0, 7))
            0: return CW'($urandom_range(0, 3) - 2);
            1: return {1'($urandom_range(0, 1)), {(CW-1){1'b0}}};
            2: return CW'($urandom >> $urandom_range(0, CW - 1));
            3: return CW'(-($urandom >> $urandom_range(0, CW - 1)));
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic vpac_pkg::in_word_t random_word();
        vpac_pkg::in_word_t w;
        w = {random_component(), random_component(), random_component(),
             random_component(), random_component(), random_component()};
        // Occasionally make one vector all zero.
        if ($urandom_range(0, 19) == 0) {w.first_x, w.first_y, w.first_z} = '0;
        if ($urandom_range(0, 19) == 0) {w.second_x, w.second_y, w.second_z} = '0;
        // Occasionally make the vectors parallel by copying the first into the second.
        if ($urandom_range(0, 9) == 0)
            {w.second_x, w.second_y, w.second_z} = {w.first_x, w.first_y, w.first_z};
        return w;
    endfunction

    // Sends one word, holding valid until it is accepted. Valid stays high
    // after acceptance so that back-to-back words need no gap.
    task automatic send_word(input vpac_pkg::in_word_t w, input vpac_pkg::out_word_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(want);
    endtask

    // Runs one idling phase of random words.
    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        vpac_pkg::in_word_t w;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            w = random_word();
            send_word(w, predict_abs_cosine(w));
        end
    endtask

    function automatic void add_row(input vpac_pkg::in_word_t w, input bit typed,
                                    input vpac_pkg::out_word_t want);
        row_t r;
        r.stim  = w;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    // Receiver: random stalls, compare against the oldest expected word.
    always @(posedge aclk) begin
        vpac_pkg::out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_data);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.unit_first_x !== want.unit_first_x)
                        $display("%0t: unit_first_x expected %h actual %h",
                                 $time, want.unit_first_x, m_data.unit_first_x);
                    if (m_data.unit_first_y !== want.unit_first_y)
                        $display("%0t: unit_first_y expected %h actual %h",
                                 $time, want.unit_first_y, m_data.unit_first_y);
                    if (m_data.unit_first_z !== want.unit_first_z)
                        $display("%0t: unit_first_z expected %h actual %h",
                                 $time, want.unit_first_z, m_data.unit_first_z);
                    if (m_data.unit_second_x !== want.unit_second_x)
                        $display("%0t: unit_second_x expected %h actual %h",
                                 $time, want.unit_second_x, m_data.unit_second_x);
                    if (m_data.unit_second_y !== want.unit_second_y)
                        $display("%0t: unit_second_y expected %h actual %h",
                                 $time, want.unit_second_y, m_data.unit_second_y);
                    if (m_data.unit_second_z !== want.unit_second_z)
                        $display("%0t: unit_second_z expected %h actual %h",
                                 $time, want.unit_second_z, m_data.unit_second_z);
                    if (m_data.abs_cosine !== want.abs_cosine)
                        $display("%0t: abs_cosine expected %h actual %h",
                                 $time, want.abs_cosine, m_data.abs_cosine);
                    if (m_data !== want) error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        localparam logic [31:0] ONE   = 32'h4000_0000;
        localparam logic [31:0] M_ONE = 32'hC000_0000;
        localparam logic [31:0] MOST_NEG = 32'h8000_0000;
        vpac_pkg::out_word_t none;
        int                  wait_cycles;
        none           = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: typed results where they are plain.
        add_row('0, 1, '0);
        add_row({32'h0001_0000, 64'd0, 32'h0001_0000, 64'd0}, 1,
                {ONE, 64'd0, ONE, 64'd0, ONE[30:0]});
        add_row({32'hFFFF_0000, 64'd0, 32'h0001_0000, 64'd0}, 1,
                {M_ONE, 64'd0, ONE, 64'd0, ONE[30:0]});
        add_row({32'h0001_0000, 64'd0, 32'd0, 32'h0000_0001, 32'd0}, 1,
                {ONE, 64'd0, 32'd0, ONE, 32'd0, 31'd0});
        add_row({MOST_NEG, 64'd0, 32'd0, 32'd0, MOST_NEG}, 1,
                {M_ONE, 64'd0, 64'd0, M_ONE, 31'd0});
        add_row({32'd0, 32'h7FFF_FFFF, 32'd0, 96'd0}, 1,
                {32'd0, ONE, 32'd0, 96'd0, 31'd0});
        add_row({96'd0, 32'd0, 32'd0, 32'hFFFF_FFFF}, 1,
                {96'd0, 64'd0, M_ONE, 31'd0});
        add_row({{3{MOST_NEG}}, {3{MOST_NEG}}}, 0, none);
        add_row({{3{32'h7FFF_FFFF}}, {3{32'h0000_0001}}}, 0, none);
        add_row({{3{32'hFFFF_FFFF}}, MOST_NEG, 32'h7FFF_FFFF, 32'h0000_0001}, 0, none);
        add_row({32'h0003_0000, 32'h0004_0000, 32'd0,
                 32'h0004_0000, 32'hFFFD_0000, 32'd0}, 0, none);
        add_row({32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A988}, 0, none);
        add_row({32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                 32'h0000_0001, 32'h0000_0002, 32'h0000_0003}, 0, none);
        foreach (directed_rows[i])
            send_word(directed_rows[i].stim,
                      directed_rows[i].typed ? directed_rows[i].want
                                             : predict_abs_cosine(directed_rows[i].stim));

        // Random phases under different idling patterns.
        run_phase(0, 0, RANDOM_WORDS / 5);
        run_phase(81, 0, RANDOM_WORDS / 5);
        run_phase(0, 81, RANDOM_WORDS / 5);
        run_phase(35, 35, RANDOM_WORDS / 5);
        run_phase(0, 0, RANDOM_WORDS / 5);
        s_valid <= 1'b0;

        // Drain, then allow the pipeline latency to expose stray words.
        recv_stall_pct = 0;
        while (expected_words.size() != 0) @(posedge aclk);
        wait_cycles = 0;
        while (wait_cycles < 2 * LATENCY) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/vpac_pkg.sv
hw/rtl/vpac_front.sv
hw/rtl/vpac_sqrt_cell.sv
hw/rtl/vpac_div_cell.sv
hw/rtl/vector_pair_abs_cosine_top.sv
dv/vector_pair_abs_cosine_top_tb.sv
